// ===== hw/rtl/vcs_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vcs_pkg
// Shared types and constants of the valid 2D convolution stream block.
// ============================================================================
package vcs_pkg;

    // Sizing of the stores.
    localparam int MAX_COLS   = 256;
    localparam int MAX_KERNEL = 8;

    localparam int LANE_W     = $clog2(MAX_KERNEL);
    localparam int KDIM_W     = $clog2(MAX_KERNEL + 1);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int COL_GRPS   = MAX_COLS / MAX_KERNEL;
    localparam int GRP_W      = $clog2(COL_GRPS);
    localparam int LINE_DEPTH = MAX_KERNEL * COL_GRPS;
    localparam int LADDR_W    = $clog2(LINE_DEPTH);
    localparam int W_TAPS     = MAX_KERNEL * MAX_KERNEL;
    localparam int TAP_W      = $clog2(W_TAPS);
    localparam int W_GRPS     = MAX_KERNEL;
    localparam int WGRP_W     = $clog2(W_GRPS);

    // Fixed field widths.
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 40;
    localparam int DIM_W      = 9;
    localparam int KREG_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int WIDX_W     = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 2'd3;

    // Operation codes of an input item.
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_PIXEL  = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    typedef struct packed {
        logic                       operation;
        logic [WIDX_W-1:0]          weight_index;
        logic signed [SAMPLE_W-1:0] weight_value;
        logic signed [SAMPLE_W-1:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] out_value;
        logic [7:0]              out_row;
        logic [7:0]              out_col;
        logic                    last;
    } out_item_t;

    // Control that travels with one kernel row of read data.
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              final_row;
        logic [LANE_W-1:0] pix_lane;
        logic [LANE_W-1:0] w_lane;
    } mac_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_HOLD
    } state_t;

endpackage

// ===== hw/rtl/vcs_weight_store.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vcs_weight_store
// Kernel weight memory, interleaved over lanes so that a run of consecutive
// taps is read together in a single access.
// ============================================================================
module vcs_weight_store
    import vcs_pkg::*;
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [WIDX_W-1:0]           wr_index,
    input  sample_t                     wr_data,
    input  logic [TAP_W-1:0]            rd_tap,
    output sample_t [MAX_KERNEL-1:0]    rd_data
);

    logic [LANE_W-1:0] wr_lane;
    logic [WGRP_W-1:0] wr_grp;
    logic              wr_ok;
    logic [LANE_W-1:0] rd_lane;
    logic [WGRP_W-1:0] rd_grp;

    // Tap t lives in lane t mod MAX_KERNEL, at group t / MAX_KERNEL.
    assign wr_ok   = ({1'b0, wr_index} < (WIDX_W + 1)'(W_TAPS));
    assign wr_lane = LANE_W'(wr_index % MAX_KERNEL);
    assign wr_grp  = WGRP_W'(wr_index / MAX_KERNEL);
    assign rd_lane = LANE_W'(rd_tap % MAX_KERNEL);
    assign rd_grp  = WGRP_W'(rd_tap / MAX_KERNEL);

    for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
        sample_t           mem [W_GRPS];
        logic [WGRP_W-1:0] rd_addr;

        // Lanes below the start lane hold taps of the following group.
        assign rd_addr = rd_grp + WGRP_W'((LANE_W'(b) < rd_lane) ? 1 : 0);

        always_ff @(posedge clk)
        begin
            if (wr_en && wr_ok && (wr_lane == LANE_W'(b)))
            begin
                mem[wr_grp] <= wr_data;
            end
            rd_data[b] <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/vcs_line_store.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vcs_line_store
// Store of the most recent image rows, interleaved over column lanes so that
// one kernel row of a window is read together in a single access.
// ============================================================================
module vcs_line_store
    import vcs_pkg::*;
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [LANE_W-1:0]           wr_row,
    input  logic [COL_W-1:0]            wr_col,
    input  sample_t                     wr_data,
    input  logic [LANE_W-1:0]           rd_row,
    input  logic [COL_W-1:0]            rd_col,
    output sample_t [MAX_KERNEL-1:0]    rd_data
);

    logic [LANE_W-1:0]  wr_lane;
    logic [LADDR_W-1:0] wr_addr;
    logic [LANE_W-1:0]  rd_lane;
    logic [GRP_W-1:0]   rd_grp;

    // Column c lives in lane c mod MAX_KERNEL, at group c / MAX_KERNEL.
    assign wr_lane = LANE_W'(wr_col % MAX_KERNEL);
    assign wr_addr = LADDR_W'(wr_row * COL_GRPS + wr_col / MAX_KERNEL);
    assign rd_lane = LANE_W'(rd_col % MAX_KERNEL);
    assign rd_grp  = GRP_W'(rd_col / MAX_KERNEL);

    for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
        sample_t            mem [LINE_DEPTH];
        logic [GRP_W-1:0]   grp;
        logic [LADDR_W-1:0] rd_addr;

        // Lanes below the window's first lane hold columns of the next group.
        assign grp     = rd_grp + GRP_W'((LANE_W'(b) < rd_lane) ? 1 : 0);
        assign rd_addr = LADDR_W'(rd_row * COL_GRPS + grp);

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_lane == LANE_W'(b)))
            begin
                mem[wr_addr] <= wr_data;
            end
            rd_data[b] <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/vcs_mac.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vcs_mac
// Aligns one kernel row of pixels and weights, multiplies the taps and adds
// the row into the window sum.
// ============================================================================
module vcs_mac
    import vcs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mac_ctrl_t                   ctrl,
    input  logic [KDIM_W-1:0]           kernel_cols,
    input  sample_t [MAX_KERNEL-1:0]    pix_data,
    input  sample_t [MAX_KERNEL-1:0]    w_data,
    output acc_t                        acc,
    output logic                        done
);

    prod_t [MAX_KERNEL-1:0] prod_reg;
    prod_t [MAX_KERNEL-1:0] prod_next;
    logic                   pv_reg;
    logic                   pfirst_reg;
    logic                   pfinal_reg;
    acc_t                   acc_reg;
    acc_t                   acc_next;
    logic                   done_reg;

    // Rotate the lanes so that tap j sits in position j, and multiply.
    always_comb
    begin
        logic [LANE_W-1:0] pl;
        logic [LANE_W-1:0] wl;
        for (int kj = 0; kj < MAX_KERNEL; kj++)
        begin
            pl = ctrl.pix_lane + LANE_W'(kj);
            wl = ctrl.w_lane + LANE_W'(kj);
            if (KDIM_W'(kj) < kernel_cols)
            begin
                prod_next[kj] = $signed(pix_data[pl]) * $signed(w_data[wl]);
            end
            else
            begin
                prod_next[kj] = '0;
            end
        end
    end

    // Add the row of products into the running window sum.
    always_comb
    begin
        acc_t row_sum;
        row_sum = '0;
        for (int kj = 0; kj < MAX_KERNEL; kj++)
        begin
            row_sum = row_sum + ACC_W'(prod_reg[kj]);
        end
        acc_next = pfirst_reg ? row_sum : acc_reg + row_sum;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (pv_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg     <= 1'b0;
            pfirst_reg <= 1'b0;
            pfinal_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            pv_reg     <= ctrl.valid;
            pfirst_reg <= ctrl.first;
            pfinal_reg <= ctrl.final_row;
            done_reg   <= pv_reg && pfinal_reg;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ===== hw/rtl/valid_conv2d_stream.sv =====
`timescale 1ns / 1ps
// ============================================================================
// valid_conv2d_stream
// Single-channel valid 2D convolution over an image streamed in raster order.
// ============================================================================
// A weight item, and a pixel item that does not complete a window, is taken
// without a stall. A pixel item that completes a window stalls the next item
// until its result is loaded: the banked line and weight memories deliver one
// kernel row of up to eight taps per cycle, followed by the registered memory
// read, one multiply stage, one accumulate stage and the load of the result
// register. A finished result waits in its register while the next items are
// taken. Any register write restarts the image at row and column zero; the
// stores keep their contents.
module valid_conv2d_stream
    import vcs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  in_item_t                item,
    output logic                    result_valid,
    input  logic                    result_stall,
    output out_item_t               result,
    input  logic                    cfg_write_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers.
    logic [DIM_W-1:0]  image_rows_reg;
    logic [DIM_W-1:0]  image_cols_reg;
    logic [KREG_W-1:0] kernel_rows_reg;
    logic [KREG_W-1:0] kernel_cols_reg;

    // Effective sizes after clamping.
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [KDIM_W-1:0] kr;
    logic [KDIM_W-1:0] kc;

    logic [DIM_W-1:0]  row_count_reg;
    logic [DIM_W-1:0]  col_count_reg;
    logic [DIM_W-1:0]  row_count_next;
    logic [DIM_W-1:0]  col_count_next;

    state_t            state_reg;
    state_t            state_next;
    logic [LANE_W-1:0] ki_reg;
    logic [LANE_W-1:0] ki_next;
    logic [COL_W-1:0]  orow_reg;
    logic [COL_W-1:0]  ocol_reg;
    logic              last_reg;
    mac_ctrl_t         mac_ctrl_reg;
    mac_ctrl_t         mac_ctrl_next;

    logic              accept;
    logic              pix_accept;
    logic              w_accept;
    logic              window;
    logic              reading;
    logic              final_read;
    logic              out_free;
    logic              out_load;

    logic [TAP_W-1:0]  tap_base;
    logic [LANE_W-1:0] rd_row;

    sample_t [MAX_KERNEL-1:0] pix_data;
    sample_t [MAX_KERNEL-1:0] w_data;
    acc_t                     acc;
    logic                     mac_done;

    out_item_t         result_reg;
    logic              result_valid_reg;

    // Clamp the register values to the supported ranges.
    always_comb
    begin
        if (image_rows_reg == '0)
            rows = DIM_W'(1);
        else if (image_rows_reg > DIM_W'(256))
            rows = DIM_W'(256);
        else
            rows = image_rows_reg;

        if (image_cols_reg == '0)
            cols = DIM_W'(1);
        else if (image_cols_reg > DIM_W'(MAX_COLS))
            cols = DIM_W'(MAX_COLS);
        else
            cols = image_cols_reg;

        if (kernel_rows_reg == '0)
            kr = KDIM_W'(1);
        else if (kernel_rows_reg > KREG_W'(MAX_KERNEL))
            kr = KDIM_W'(MAX_KERNEL);
        else
            kr = KDIM_W'(kernel_rows_reg);

        if (kernel_cols_reg == '0)
            kc = KDIM_W'(1);
        else if (kernel_cols_reg > KREG_W'(MAX_KERNEL))
            kc = KDIM_W'(MAX_KERNEL);
        else
            kc = KDIM_W'(kernel_cols_reg);
    end

    // Item handshake decode.
    assign accept     = item_valid && !item_stall;
    assign pix_accept = accept && (item.operation == OP_PIXEL);
    assign w_accept   = accept && (item.operation == OP_WEIGHT);
    assign window     = ((row_count_reg + DIM_W'(1)) >= DIM_W'(kr))
                     && ((col_count_reg + DIM_W'(1)) >= DIM_W'(kc));
    assign final_read = ({1'b0, ki_reg} == (KDIM_W'(kr) - KDIM_W'(1)));
    assign out_free   = !result_valid_reg || !result_stall;

    // Position of the next pixel in raster order.
    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (cfg_write_en)
        begin
            row_count_next = '0;
            col_count_next = '0;
        end
        else if (pix_accept)
        begin
            if ((col_count_reg + DIM_W'(1)) >= cols)
            begin
                col_count_next = '0;
                if ((row_count_reg + DIM_W'(1)) >= rows)
                    row_count_next = '0;
                else
                    row_count_next = row_count_reg + DIM_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + DIM_W'(1);
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pix_accept && window)
                    state_next = S_READ;
            end
            S_READ:
            begin
                if (final_read)
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (mac_done)
                    state_next = out_free ? S_IDLE : S_HOLD;
            end
            S_HOLD:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        item_stall = 1'b1;
        reading    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
            end
            S_READ:
            begin
                reading = 1'b1;
            end
            S_WAIT:
            begin
                out_load = mac_done && out_free;
            end
            S_HOLD:
            begin
                out_load = out_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // Read addressing for kernel row ki of the window.
    assign tap_base = TAP_W'(ki_reg) * TAP_W'(kc);
    assign rd_row   = LANE_W'((orow_reg + ki_reg) % MAX_KERNEL);
    assign ki_next  = reading ? ki_reg + LANE_W'(1) : '0;

    always_comb
    begin
        mac_ctrl_next.valid     = reading;
        mac_ctrl_next.first     = (ki_reg == '0);
        mac_ctrl_next.final_row = final_read;
        mac_ctrl_next.pix_lane  = LANE_W'(ocol_reg % MAX_KERNEL);
        mac_ctrl_next.w_lane    = LANE_W'(tap_base % MAX_KERNEL);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg   <= DIM_W'(28);
            image_cols_reg   <= DIM_W'(28);
            kernel_rows_reg  <= KREG_W'(3);
            kernel_cols_reg  <= KREG_W'(3);
            row_count_reg    <= '0;
            col_count_reg    <= '0;
            state_reg        <= S_IDLE;
            ki_reg           <= '0;
            mac_ctrl_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_IMAGE_ROWS:  image_rows_reg  <= cfg_data;
                    CFG_IMAGE_COLS:  image_cols_reg  <= cfg_data;
                    CFG_KERNEL_ROWS: kernel_rows_reg <= cfg_data[KREG_W-1:0];
                    CFG_KERNEL_COLS: kernel_cols_reg <= cfg_data[KREG_W-1:0];
                    default:         image_rows_reg  <= image_rows_reg;
                endcase
            end
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            state_reg     <= state_next;
            ki_reg        <= ki_next;
            mac_ctrl_reg  <= mac_ctrl_next;
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // Window position of the item in progress, and the result register.
    always_ff @(posedge clk)
    begin
        if (pix_accept && window)
        begin
            orow_reg <= COL_W'(row_count_reg + DIM_W'(1) - DIM_W'(kr));
            ocol_reg <= COL_W'(col_count_reg + DIM_W'(1) - DIM_W'(kc));
            last_reg <= (row_count_reg == rows - DIM_W'(1))
                     && (col_count_reg == cols - DIM_W'(1));
        end
        if (out_load)
        begin
            result_reg.out_value <= acc;
            result_reg.out_row   <= 8'(orow_reg);
            result_reg.out_col   <= 8'(ocol_reg);
            result_reg.last      <= last_reg;
        end
    end

    vcs_weight_store u_weight_store (
        .clk      (clk),
        .wr_en    (w_accept),
        .wr_index (item.weight_index),
        .wr_data  (item.weight_value),
        .rd_tap   (tap_base),
        .rd_data  (w_data)
    );

    vcs_line_store u_line_store (
        .clk      (clk),
        .wr_en    (pix_accept),
        .wr_row   (LANE_W'(row_count_reg % MAX_KERNEL)),
        .wr_col   (COL_W'(col_count_reg)),
        .wr_data  (item.pixel),
        .rd_row   (rd_row),
        .rd_col   (ocol_reg),
        .rd_data  (pix_data)
    );

    vcs_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (mac_ctrl_reg),
        .kernel_cols (kc),
        .pix_data    (pix_data),
        .w_data      (w_data),
        .acc         (acc),
        .done        (mac_done)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
